/* rtl/binary_grid_3x3_count_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 grid count block
// Shared concurrent check forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_GRID_3X3_COUNT_TOP_MACROS_SVH
`define BINARY_GRID_3X3_COUNT_TOP_MACROS_SVH

// check in the same cycle
`define BGC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check in the next cycle
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bgc_pkg.sv */
// ----------------------------------------------------------------------------
// bgc_pkg
// Types, register codes and count helpers for the 3x3 grid count block.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam int CFG_DATA_W = 11;
    localparam int GRID_W_BITS = 6;
    localparam int COUNT_W = 4;

    typedef struct packed {
        logic       cell_bit;
        logic       col_zero;
        logic       row_zero;
        logic       row_one;
        logic       res_mid;
        logic       res_edge;
        logic       res_flush;
        logic       fwd;
        logic [1:0] fwd_data;
    } t_item;

    typedef struct packed {
        logic run;
        logic adv;
    } t_stage_ctl;

    function automatic logic [COUNT_W-1:0] pop9(input logic [8:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 9; i++) begin
            n = n + {{(COUNT_W-1){1'b0}}, v[i]};
        end
        return n;
    endfunction

    function automatic logic [1:0] pop2(input logic [1:0] e);
        return {1'b0, e[0]} + {1'b0, e[1]};
    endfunction

endpackage

/* rtl/binary_grid_3x3_count_top.sv */
// ----------------------------------------------------------------------------
// binary_grid_3x3_count_top
// Counts set cells in the 3x3 window of every cell of a raster binary grid.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one item per cycle unless stalled; each result
// leaves one row and one column behind its input. The last cell of a row
// below the first gives two results, stalling input for the second. A frame's
// last cell stalls input while sweeping the line RAM through its one read
// port, giving the last row one result per cycle while the output is ready.
// A configuration write restarts the frame; no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "binary_grid_3x3_count_top_macros.svh"

module binary_grid_3x3_count_top
    import bgc_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cell_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COUNT_W-1:0]    o_neighbor_count,
    output logic                  o_frame_end,
    output logic                  o_run_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    t_stage_ctl    ctl;
    t_item         item;
    logic          item_vld;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] wlast;
    logic          restart;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;
    logic          scan_rd_en;
    logic [AW-1:0] scan_rd_addr;
    logic          win_rd_en;
    logic [AW-1:0] win_rd_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [1:0]    rd_data;

    bgc_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cell_req  (i_cell_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_en     (scan_rd_en),
        .o_rd_addr   (scan_rd_addr),
        .o_item_vld  (item_vld),
        .o_item      (item),
        .o_item_addr (item_addr),
        .o_wlast     (wlast),
        .o_restart   (restart)
    );

    assign rd_en   = scan_rd_en || win_rd_en;
    assign rd_addr = win_rd_en ? win_rd_addr : scan_rd_addr;

    bgc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bgc_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_restart        (restart),
        .i_item_vld       (item_vld),
        .i_item           (item),
        .i_item_addr      (item_addr),
        .i_wlast          (wlast),
        .i_rd_data        (rd_data),
        .o_ctl            (ctl),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_rd_en          (win_rd_en),
        .o_rd_addr        (win_rd_addr),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_neighbor_count (o_neighbor_count),
        .o_frame_end      (o_frame_end),
        .o_run_last       (o_run_last)
    );

    `BGC_ASSERT_SAME(a_rd_port, scan_rd_en, !win_rd_en, "line RAM read port claimed twice")
    `BGC_ASSERT_SAME(a_wr_no_sweep, wr_en, !win_rd_en, "line RAM write during final row sweep")

endmodule

/* rtl/bgc_ram.sv */
// ----------------------------------------------------------------------------
// bgc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bgc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bgc_scan.sv */
// ----------------------------------------------------------------------------
// bgc_scan
// Configuration registers, raster position and input stage with line read.
// ----------------------------------------------------------------------------
`include "binary_grid_3x3_count_top_macros.svh"

module bgc_scan
    import bgc_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cell_req,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  t_stage_ctl                    i_ctl,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  logic [1:0]                    i_wr_data,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_rd_addr,
    output logic                          o_item_vld,
    output t_item                         o_item,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_item_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_wlast,
    output logic                          o_restart
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_W = (32 > MAX_WIDTH) ? MAX_WIDTH : 32;
    localparam int RST_H = (32 > MAX_HEIGHT) ? MAX_HEIGHT : 32;

    logic [AW-1:0]          r_wlast;
    logic [RW-1:0]          r_hlast;
    logic [AW-1:0]          r_col;
    logic [RW-1:0]          r_row;
    logic                   r_p_vld;
    t_item                  r_item;
    logic [AW-1:0]          r_addr;

    logic [GRID_W_BITS-1:0] cfg_w;
    logic [CFG_DATA_W-1:0]  cfg_h;
    logic [AW-1:0]          cfg_wlast;
    logic [RW-1:0]          cfg_hlast;
    logic                   accept;
    logic                   col_end;
    t_item                  n_item;

    assign cfg_w = i_cfg_data[GRID_W_BITS-1:0];
    assign cfg_h = i_cfg_data;

    always_comb begin
        if (cfg_w == '0) begin
            cfg_wlast = '0;
        end else if (cfg_w > GRID_W_BITS'(MAX_WIDTH)) begin
            cfg_wlast = AW'(MAX_WIDTH - 1);
        end else begin
            cfg_wlast = AW'(cfg_w - GRID_W_BITS'(1));
        end
        if (cfg_h == '0) begin
            cfg_hlast = '0;
        end else if (32'(cfg_h) > MAX_HEIGHT) begin
            cfg_hlast = RW'(MAX_HEIGHT - 1);
        end else begin
            cfg_hlast = RW'(cfg_h - CFG_DATA_W'(1));
        end
    end

    assign o_in_ready = i_ctl.run && (!r_p_vld || i_ctl.adv);
    assign accept     = i_in_valid && o_in_ready;
    assign col_end    = (r_col == r_wlast);

    always_comb begin
        n_item.cell_bit  = i_cell_req;
        n_item.col_zero  = (r_col == '0);
        n_item.row_zero  = (r_row == '0);
        n_item.row_one   = (r_row == RW'(1));
        n_item.res_mid   = (r_row != '0) && (r_col != '0);
        n_item.res_edge  = (r_row != '0) && col_end;
        n_item.res_flush = (r_row == r_hlast) && col_end;
        n_item.fwd       = i_wr_en && (i_wr_addr == r_col);
        n_item.fwd_data  = i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= AW'(RST_W - 1);
            r_hlast <= RW'(RST_H - 1);
            r_col   <= '0;
            r_row   <= '0;
            r_p_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_GRID_WIDTH:  r_wlast <= cfg_wlast;
                    REG_GRID_HEIGHT: r_hlast <= cfg_hlast;
                    default:         r_wlast <= r_wlast;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= (r_row == r_hlast) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
            if (accept) begin
                r_p_vld <= 1'b1;
            end else if (i_ctl.adv) begin
                r_p_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
            r_addr <= r_col;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_rd_en     = accept;
    assign o_rd_addr   = r_col;
    assign o_item_vld  = r_p_vld;
    assign o_item      = r_item;
    assign o_item_addr = r_addr;
    assign o_wlast     = r_wlast;
    assign o_restart   = i_cfg_valid;

    `BGC_ASSERT_NEXT(a_item_hold, r_p_vld && !i_ctl.adv, $stable(r_addr) && $stable(r_item), "held item changed")
    `BGC_ASSERT_SAME(a_accept_run, accept, i_ctl.run, "item taken while window stage busy")
    `BGC_ASSERT_SAME(a_pos_range, 1'b1, (r_col <= r_wlast) && (r_row <= r_hlast), "position out of grid")

endmodule

/* rtl/bgc_win.sv */
// ----------------------------------------------------------------------------
// bgc_win
// Window update, line write-back, final row sweep and output register.
// ----------------------------------------------------------------------------
`include "binary_grid_3x3_count_top_macros.svh"

module bgc_win
    import bgc_pkg::*;
#(
    parameter int MAX_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic                          i_item_vld,
    input  t_item                         i_item,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_item_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wlast,
    input  logic [1:0]                    i_rd_data,
    output t_stage_ctl                    o_ctl,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_wr_addr,
    output logic [1:0]                    o_wr_data,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_rd_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COUNT_W-1:0]            o_neighbor_count,
    output logic                          o_frame_end,
    output logic                          o_run_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_WIDTH + 2);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_EDGE  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]         r_st;
    logic [1:0]         n_st;
    logic [8:0]         r_win;
    logic               r_fl_pend;
    logic [FW-1:0]      r_ft;
    logic [1:0]         r_wa;
    logic [1:0]         r_wb;
    logic               r_o_vld;
    logic [COUNT_W-1:0] r_o_cnt;
    logic               r_o_fend;
    logic               r_o_last;
    logic               n_o_load;
    logic [COUNT_W-1:0] n_o_cnt;
    logic               n_o_fend;
    logic               n_o_last;

    logic [1:0]         s;
    logic               older;
    logic               newer;
    logic [8:0]         win_new;
    logic               first_vld;
    logic [COUNT_W-1:0] first_cnt;
    logic               pend_edge;
    logic               out_free;
    logic               run;
    logic               adv;
    logic [FW-1:0]      wl_ext;
    logic [1:0]         f_new;
    logic               f_emit;
    logic               f_done;
    logic               f_go;
    logic [COUNT_W-1:0] f_sum;

    always_comb begin
        s       = i_item.fwd ? i_item.fwd_data : i_rd_data;
        older   = (i_item.row_zero || i_item.row_one) ? 1'b0 : s[1];
        newer   = i_item.row_zero ? 1'b0 : s[0];
        win_new = {i_item.cell_bit, newer, older, (i_item.col_zero ? 6'd0 : r_win[8:3])};
        first_vld = i_item.res_mid || i_item.res_edge;
        first_cnt = i_item.res_mid ? pop9(win_new) : pop9({3'b000, win_new[8:3]});
        pend_edge = i_item.res_mid && i_item.res_edge;
    end

    assign out_free = !r_o_vld || i_out_ready;
    assign run      = (r_st == ST_RUN);
    assign adv      = i_item_vld && run && (out_free || !first_vld);

    always_comb begin
        wl_ext = FW'(i_wlast);
        f_new  = ((r_ft != '0) && (r_ft <= wl_ext + FW'(1))) ? pop2(i_rd_data) : 2'd0;
        f_emit = (r_ft >= FW'(2));
        f_done = (r_ft == wl_ext + FW'(2));
        f_go   = (r_st == ST_FLUSH) && (!f_emit || out_free);
        f_sum  = COUNT_W'(r_wa) + COUNT_W'(r_wb) + COUNT_W'(f_new);
    end

    always_comb begin
        n_st     = r_st;
        n_o_load = 1'b0;
        n_o_cnt  = first_cnt;
        n_o_fend = 1'b0;
        n_o_last = 1'b0;
        unique case (r_st)
            ST_RUN: begin
                if (adv) begin
                    n_o_load = first_vld;
                    n_o_last = !pend_edge && !i_item.res_flush;
                    if (pend_edge) begin
                        n_st = ST_EDGE;
                    end else if (i_item.res_flush) begin
                        n_st = ST_FLUSH;
                    end
                end
            end
            ST_EDGE: begin
                if (out_free) begin
                    n_o_load = 1'b1;
                    n_o_cnt  = pop9({3'b000, r_win[8:3]});
                    n_o_last = !r_fl_pend;
                    n_st     = r_fl_pend ? ST_FLUSH : ST_RUN;
                end
            end
            ST_FLUSH: begin
                if (f_go) begin
                    n_o_load = f_emit;
                    n_o_cnt  = f_sum;
                    n_o_fend = f_done;
                    n_o_last = f_done;
                    if (f_done) begin
                        n_st = ST_RUN;
                    end
                end
            end
            default: begin
                n_st = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_RUN;
            r_win     <= '0;
            r_fl_pend <= 1'b0;
            r_ft      <= '0;
            r_wa      <= '0;
            r_wb      <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_restart) begin
                r_win <= '0;
            end else if (adv) begin
                r_win     <= win_new;
                r_fl_pend <= i_item.res_flush;
            end
            if (r_st != ST_FLUSH) begin
                r_ft <= '0;
                r_wa <= '0;
                r_wb <= '0;
            end else if (f_go) begin
                r_ft <= r_ft + FW'(1);
                r_wa <= r_wb;
                r_wb <= f_new;
            end
            if (n_o_load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_o_load) begin
            r_o_cnt  <= n_o_cnt;
            r_o_fend <= n_o_fend;
            r_o_last <= n_o_last;
        end
    end

    assign o_ctl.run        = run;
    assign o_ctl.adv        = adv;
    assign o_wr_en          = adv;
    assign o_wr_addr        = i_item_addr;
    assign o_wr_data        = {newer, i_item.cell_bit};
    assign o_rd_en          = f_go && (r_ft <= wl_ext);
    assign o_rd_addr        = r_ft[AW-1:0];
    assign o_out_valid      = r_o_vld;
    assign o_neighbor_count = r_o_cnt;
    assign o_frame_end      = r_o_fend;
    assign o_run_last       = r_o_last;

    `BGC_ASSERT_SAME(a_count_range, r_o_vld, r_o_cnt <= COUNT_W'(9), "count above nine")
    `BGC_ASSERT_SAME(a_fend_last, r_o_vld && r_o_fend, r_o_last, "frame end not on last result")
    `BGC_ASSERT_SAME(a_edge_entry, r_st == ST_EDGE, $past(adv) || $past(r_st == ST_EDGE), "edge state without item")

endmodule
